@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tesp_pkg.sv @@
// Package with the types and codes of the triangle edge split emitter.
package tesp_pkg;

	localparam int ID_BITS = 24;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] rot_t;

	// Number of split edges; it is also the index of the last triangle of a run.
	localparam kind_t KIND_NONE  = 2'd0;
	localparam kind_t KIND_ONE   = 2'd1;
	localparam kind_t KIND_TWO   = 2'd2;
	localparam kind_t KIND_THREE = 2'd3;

	// A classified triangle with corners and midpoints already rotated.
	typedef struct packed {
		id_t [2:0] corner;
		id_t [2:0] mid;
		kind_t     kind;
	} entry_t;

endpackage

@@ hw/rtl/triangle_edge_split_emitter.sv @@
// The first triangle of an item passes the front stage register, the queue and the
// output register of the back stage. Throughput: one triangle per cycle while the output
// is not stalled, as the back stage emitter sets; an item yields one to four triangles.
// A two-entry queue lets the front keep accepting while the output is stalled.
// Reset is asynchronous and active low; it empties every stage and the queue.
module triangle_edge_split_emitter import tesp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  id_t  corner_a,
	input  id_t  corner_b,
	input  id_t  corner_c,
	input  id_t  mid_zero,
	input  id_t  mid_one,
	input  id_t  mid_two,
	input  logic split_zero,
	input  logic split_one,
	input  logic split_two,
	output logic out_valid,
	input  logic out_stall,
	output id_t  out_first,
	output id_t  out_second,
	output id_t  out_third,
	output logic last_in_run
);

	logic   push;
	entry_t push_entry;
	logic   queue_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	tesp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.corner_a   (corner_a),
		.corner_b   (corner_b),
		.corner_c   (corner_c),
		.mid_zero   (mid_zero),
		.mid_one    (mid_one),
		.mid_two    (mid_two),
		.split_zero (split_zero),
		.split_one  (split_one),
		.split_two  (split_two),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	tesp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tesp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_first   (out_first),
		.out_second  (out_second),
		.out_third   (out_third),
		.last_in_run (last_in_run)
	);

endmodule

@@ hw/rtl/tesp_front.sv @@
// Front stage: accepts triangles, counts split edges and rotates the corners.
module tesp_front import tesp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  id_t    corner_a,
	input  id_t    corner_b,
	input  id_t    corner_c,
	input  id_t    mid_zero,
	input  id_t    mid_one,
	input  id_t    mid_two,
	input  logic   split_zero,
	input  logic   split_one,
	input  logic   split_two,
	output logic   push,
	output entry_t push_entry,
	input  logic   queue_full
);

	logic      valid_s1;
	entry_t    entry_s1;
	logic [2:0] split;
	logic [2:0] odd;
	kind_t     kind;
	rot_t      rot;
	entry_t    entry_d;

	assign split = {split_two, split_one, split_zero};
	assign kind  = kind_t'({1'b0, split[0]} + {1'b0, split[1]} + {1'b0, split[2]});

	// The edge that differs from the other two sets the rotation.
	always_comb begin
		odd = (kind == KIND_TWO) ? ~split : split;
		rot = 2'd0;
		if (kind == KIND_ONE || kind == KIND_TWO) begin
			if (odd[1]) begin
				rot = 2'd1;
			end else if (odd[2]) begin
				rot = 2'd2;
			end
		end
	end

	always_comb begin
		entry_d.kind = kind;
		unique case (rot)
			2'd1: begin
				entry_d.corner = {corner_a, corner_c, corner_b};
				entry_d.mid    = {mid_zero, mid_two, mid_one};
			end
			2'd2: begin
				entry_d.corner = {corner_b, corner_a, corner_c};
				entry_d.mid    = {mid_one, mid_zero, mid_two};
			end
			default: begin
				entry_d.corner = {corner_c, corner_b, corner_a};
				entry_d.mid    = {mid_two, mid_one, mid_zero};
			end
		endcase
	end

	assign push       = valid_s1 && !queue_full;
	assign in_stall   = valid_s1 && queue_full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

@@ hw/rtl/tesp_queue.sv @@
// Two-entry queue between the front stage and the triangle emitter.
module tesp_queue import tesp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ hw/rtl/tesp_back.sv @@
// Back stage: emits the refined triangles of the queue head, one per cycle while out_stall is low.
module tesp_back import tesp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  entry_t head,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_stall,
	output id_t    out_first,
	output id_t    out_second,
	output id_t    out_third,
	output logic   last_in_run
);

	logic [1:0] step_q;
	logic       out_valid_q;
	id_t        first_q;
	id_t        second_q;
	id_t        third_q;
	logic       last_q;
	logic       load;
	logic       final_step;
	id_t        tri_a;
	id_t        tri_b;
	id_t        tri_c;

	assign load       = !out_valid_q || !out_stall;
	assign final_step = (step_q == head.kind);
	assign pop        = head_valid && load && final_step;

	always_comb begin
		tri_a = head.corner[0];
		tri_b = head.corner[1];
		tri_c = head.corner[2];
		unique case (head.kind)
			KIND_NONE: begin
				tri_a = head.corner[0];
			end
			KIND_ONE: begin
				if (step_q == 2'd0) begin
					tri_a = head.corner[2];
				end else begin
					tri_a = head.corner[0];
				end
				tri_b = head.corner[1];
				tri_c = head.mid[0];
			end
			KIND_TWO: begin
				case (step_q)
					2'd0: begin
						tri_a = head.corner[1];
						tri_b = head.mid[1];
						tri_c = head.mid[2];
					end
					2'd1: begin
						tri_a = head.corner[0];
						tri_b = head.mid[2];
						tri_c = head.mid[1];
					end
					default: begin
						tri_a = head.corner[0];
						tri_b = head.corner[2];
						tri_c = head.mid[2];
					end
				endcase
			end
			KIND_THREE: begin
				case (step_q)
					2'd0: begin
						tri_a = head.corner[0];
						tri_b = head.mid[1];
						tri_c = head.mid[0];
					end
					2'd1: begin
						tri_a = head.mid[1];
						tri_b = head.corner[1];
						tri_c = head.mid[2];
					end
					2'd2: begin
						tri_a = head.mid[0];
						tri_b = head.mid[2];
						tri_c = head.corner[2];
					end
					default: begin
						tri_a = head.mid[1];
						tri_b = head.mid[2];
						tri_c = head.mid[0];
					end
				endcase
			end
			default: begin
				tri_a = head.corner[0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= final_step ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			first_q  <= tri_a;
			second_q <= tri_b;
			third_q  <= tri_c;
			last_q   <= final_step;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_first   = first_q;
	assign out_second  = second_q;
	assign out_third   = third_q;
	assign last_in_run = last_q;

endmodule

@@ hw/rtl/tesp_checker.sv @@
// Port-level checker for the triangle edge split emitter, with its bind statement.
`include "assert_macros.svh"

module tesp_checker import tesp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input id_t  corner_a,
	input id_t  corner_b,
	input id_t  corner_c,
	input id_t  mid_zero,
	input id_t  mid_one,
	input id_t  mid_two,
	input logic split_zero,
	input logic split_one,
	input logic split_two,
	input logic out_valid,
	input logic out_stall,
	input id_t  out_first,
	input id_t  out_second,
	input id_t  out_third,
	input logic last_in_run
);

	logic [2:0] pending_q;
	logic       in_take;
	logic       run_done;

	assign in_take  = in_valid && !in_stall;
	assign run_done = out_valid && !out_stall && last_in_run;

	// Items accepted whose last triangle has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (in_take && !run_done) begin
			pending_q <= pending_q + 3'd1;
		end else if (run_done && !in_take) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !out_valid, "output valid during reset")
	`ASSERT_RST(a_no_phantom, out_valid |-> pending_q != 3'd0, "triangle without an item")
	`ASSERT_RST(a_bounded, pending_q <= 3'd4, "more items in flight than storage")
	`ASSERT_RST(a_hold, out_valid && out_stall |=> out_valid && $stable(out_first) && $stable(out_second) && $stable(out_third) && $stable(last_in_run), "stalled triangle changed")

endmodule

bind triangle_edge_split_emitter tesp_checker u_tesp_checker (.*);
